>>> rtl/core/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg
// Shared types and constants for the signed integer to decimal text core.
// ----------------------------------------------------------------------------
package sida_pkg;

  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned NUM_DIGITS    = 10;
  localparam int unsigned BCD_W         = 4 * NUM_DIGITS;
  localparam int unsigned BITS_PER_STEP = 2;
  localparam int unsigned CONV_STEPS    = VALUE_W / BITS_PER_STEP;
  localparam int unsigned STEP_W        = $clog2(CONV_STEPS);
  localparam int unsigned DIG_CNT_W     = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd48;
  localparam logic [CHAR_W-1:0] MINUS_SIGN = 8'd45;

  // one-hot controller states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_SKIP = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;        // capture magnitude and sign, clear digit register
    logic conv;        // one double-dabble step
    logic skip;        // drop a leading zero digit
    logic emit_sign;   // put the minus sign on the output
    logic emit_digit;  // put the top digit on the output and shift it out
  } dp_cmd_t;

  typedef struct packed {
    logic negative;
    logic top_zero;
    logic one_left;
  } dp_status_t;

endpackage

>>> rtl/core/sida_dp.sv
// ----------------------------------------------------------------------------
// sida_dp
// Datapath: magnitude, double-dabble digit register and output registers.
// ----------------------------------------------------------------------------
module sida_dp
  import sida_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [VALUE_W-1:0] value_i,
  input  dp_cmd_t                  cmd_i,
  output dp_status_t               status_o,
  output logic [CHAR_W-1:0]        character_o,
  output logic                     last_o,
  output logic                     valid_o
);

  logic [VALUE_W-1:0]   mag_q, mag_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d;
  logic                 neg_q, neg_d;
  logic [DIG_CNT_W-1:0] left_q, left_d;
  logic [CHAR_W-1:0]    char_q, char_d;
  logic                 last_q, last_d;
  logic                 valid_q;

  logic [BCD_W-1:0]     dd_bcd;
  logic [VALUE_W-1:0]   dd_mag;
  logic [3:0]           top_digit;

  assign top_digit = bcd_q[BCD_W-1 -: 4];

  // double dabble, BITS_PER_STEP bits per cycle
  always_comb begin
    dd_bcd = bcd_q;
    dd_mag = mag_q;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (dd_bcd[4*d +: 4] >= 4'd5) begin
          dd_bcd[4*d +: 4] = dd_bcd[4*d +: 4] + 4'd3;
        end
      end
      dd_bcd = {dd_bcd[BCD_W-2:0], dd_mag[VALUE_W-1]};
      dd_mag = {dd_mag[VALUE_W-2:0], 1'b0};
    end
  end

  always_comb begin
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    neg_d  = neg_q;
    left_d = left_q;
    char_d = char_q;
    last_d = last_q;
    if (cmd_i.load) begin
      neg_d  = value_i[VALUE_W-1];
      mag_d  = value_i[VALUE_W-1] ? (~value_i + 1'b1) : value_i;
      bcd_d  = '0;
      left_d = DIG_CNT_W'(NUM_DIGITS);
    end
    if (cmd_i.conv) begin
      mag_d = dd_mag;
      bcd_d = dd_bcd;
    end
    if (cmd_i.skip || cmd_i.emit_digit) begin
      bcd_d  = {bcd_q[BCD_W-5:0], 4'h0};
      left_d = left_q - 1'b1;
    end
    if (cmd_i.emit_sign) begin
      char_d = MINUS_SIGN;
      last_d = 1'b0;
    end
    if (cmd_i.emit_digit) begin
      char_d = DIGIT_BASE + {4'h0, top_digit};
      last_d = (left_q == DIG_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    left_q <= left_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit_sign | cmd_i.emit_digit;
    end
  end

  assign status_o.negative = neg_q;
  assign status_o.top_zero = (top_digit == 4'h0);
  assign status_o.one_left = (left_q == DIG_CNT_W'(1));

  assign character_o = char_q;
  assign last_o      = last_q;
  assign valid_o     = valid_q;

endmodule

>>> rtl/core/sida_ctrl.sv
// ----------------------------------------------------------------------------
// sida_ctrl
// Controller: sequences conversion, sign, leading-zero skip and digit output.
// ----------------------------------------------------------------------------
module sida_ctrl
  import sida_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        step_d     = step_q + 1'b1;
        if (step_q == STEP_W'(CONV_STEPS - 1)) begin
          state_d = status_i.negative ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        cmd_o.emit_sign = 1'b1;
        state_d         = ST_SKIP;
      end
      ST_SKIP: begin
        // keep at least one digit so zero prints as '0'
        if (status_i.top_zero && !status_i.one_left) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_digit = 1'b1;
        if (status_i.one_left) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");

  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.conv, cmd_o.skip, cmd_o.emit_sign, cmd_o.emit_digit}))
    else $error("more than one datapath command at once");

  a_conv_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV && step_q != STEP_W'(CONV_STEPS - 1)) |=> state_q == ST_CONV)
    else $error("conversion left early");

endmodule

>>> rtl/core/signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a 32-bit two's complement integer to its decimal ASCII text.
// ----------------------------------------------------------------------------
// usage:
//   drive value_i and raise start; the value is taken at a rising edge where
//   start is high and busy is low. busy stays high until the last character
//   of the transaction has been scheduled.
//   characters come out most significant first on character_o, each for one
//   cycle with valid_o high; a negative value starts with '-'. last_o marks
//   the final character. leading zeros are dropped, zero gives '0'.
//   sequence: double dabble through the digit register at 2 bits per cycle,
//   then the sign if negative, then a check state that drops leading zeros
//   one at a time, then the printed digits. a new value can be taken in the
//   cycle busy drops.
//   the receiver cannot stall: every character must be taken when shown.
//   reset returns the controller to idle and clears valid_o.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core
  import sida_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      valid_o,
  output logic [CHAR_W-1:0]         character_o,
  output logic                      last_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sida_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  sida_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .character_o (character_o),
    .last_o      (last_o),
    .valid_o     (valid_o)
  );

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (character_o == MINUS_SIGN ||
                 (character_o >= DIGIT_BASE && character_o <= DIGIT_BASE + 8'd9)))
    else $error("character out of range");

  a_done_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (valid_o && last_o))
    else $error("transaction ended without a last character");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && character_o == MINUS_SIGN) |-> !last_o)
    else $error("minus sign flagged as last");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

endmodule
